[src/spi_nor_flash_sector_sequencer_top_macros.svh]
// Assertion macros shared by the sector sequencer checkers.
`ifndef SPI_NOR_FLASH_SECTOR_SEQUENCER_TOP_MACROS_SVH
`define SPI_NOR_FLASH_SECTOR_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SSQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sector sequencer check failed");

// Next-cycle implication, disabled while reset is low.
`define SSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sector sequencer check failed");

`endif

[src/ssq_pkg.sv]
// Shared types and codes of the SPI NOR flash sector sequencer.
package ssq_pkg;

    localparam int PAGE_BYTES_DEF   = 256;
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [15:0] TIMEOUT_RST = 16'd5000;
    localparam logic [3:0]  RETRY_RST   = 4'd5;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_RETRY   = 2'd1;

    localparam logic [2:0] ACT_INIT   = 3'd0;
    localparam logic [2:0] ACT_READ   = 3'd1;
    localparam logic [2:0] ACT_LOAD   = 3'd2;
    localparam logic [2:0] ACT_WRITE  = 3'd3;
    localparam logic [2:0] ACT_STATUS = 3'd4;
    localparam logic [2:0] ACT_RX     = 3'd5;
    localparam logic [2:0] ACT_TICK   = 3'd6;
    localparam logic [2:0] ACT_ID     = 3'd7;

    localparam logic [1:0] K_SPI   = 2'd0;
    localparam logic [1:0] K_RDATA = 2'd1;
    localparam logic [1:0] K_DONE  = 2'd2;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_PARAM = 3'd1;
    localparam logic [2:0] ERR_NRDY  = 3'd2;
    localparam logic [2:0] ERR_WEN   = 3'd3;
    localparam logic [2:0] ERR_ERASE = 3'd4;
    localparam logic [2:0] ERR_PROG  = 3'd5;
    localparam logic [2:0] ERR_WAIT  = 3'd6;

    typedef struct packed {
        logic [2:0]  action;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  data_byte;
        logic        link_ok;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic        frame_end;
        logic        success;
        logic [2:0]  error_code;
        logic [23:0] jedec_id;
        logic        device_ready;
        logic        last;
    } t_res;

endpackage

[src/ssq_ram.sv]
// Generic single-port-write, registered-read RAM.
module ssq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/ssq_front.sv]
// Front end: accepts input beats into a short queue for the sequencer.
module ssq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ssq_pkg::t_item i_item,
    input  logic          i_pop,
    output logic          o_avail,
    output ssq_pkg::t_item o_item
);
    import ssq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          push, pop;

    assign o_stall = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign push    = i_valid && !o_stall;
    assign o_avail = (r_cnt != '0);
    assign pop     = i_pop && o_avail;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

[src/ssq_outq.sv]
// Result queue: takes up to two results a cycle, sends one beat a cycle while i_stall is low.
module ssq_outq (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [1:0]   i_push_n,
    input  ssq_pkg::t_res i_res0,
    input  ssq_pkg::t_res i_res1,
    output logic         o_room2,
    output logic         o_valid,
    input  logic         i_stall,
    output ssq_pkg::t_res o_res
);
    import ssq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_res          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign o_res   = r_mem[r_rp];
    assign o_room2 = (r_cnt <= (PW+1)'(QUEUE_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(i_push_n);
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push_n) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wp + 1'b1] <= i_res1;
        end
    end
endmodule

[src/ssq_back.sv]
// Back end: flash command sequencer, one queued item per cycle while i_go is high.
module ssq_back #(
    parameter int PAGE_BYTES   = ssq_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = ssq_pkg::SECTOR_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_go,
    input  ssq_pkg::t_item i_item,
    output logic [1:0]    o_push_n,
    output ssq_pkg::t_res  o_res0,
    output ssq_pkg::t_res  o_res1
);
    import ssq_pkg::*;

    localparam int AW = $clog2(SECTOR_BYTES);

    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_RST1    = 5'd1;
    localparam logic [4:0] PH_RST2    = 5'd2;
    localparam logic [4:0] PH_DLY1    = 5'd3;
    localparam logic [4:0] PH_REL     = 5'd4;
    localparam logic [4:0] PH_DLY2    = 5'd5;
    localparam logic [4:0] PH_INIT_ID = 5'd6;
    localparam logic [4:0] PH_DLY3    = 5'd7;
    localparam logic [4:0] PH_READ    = 5'd8;
    localparam logic [4:0] PH_STAT    = 5'd9;
    localparam logic [4:0] PH_IDREAD  = 5'd10;
    localparam logic [4:0] PH_W_WEN   = 5'd11;
    localparam logic [4:0] PH_W_WEL   = 5'd12;
    localparam logic [4:0] PH_W_ERASE = 5'd13;
    localparam logic [4:0] PH_W_POLL  = 5'd14;
    localparam logic [4:0] PH_P_WEN   = 5'd15;
    localparam logic [4:0] PH_P_WEL   = 5'd16;
    localparam logic [4:0] PH_P_PROG  = 5'd17;
    localparam logic [4:0] PH_P_POLL  = 5'd18;

    localparam logic [2:0] FR_CMD   = 3'd0;
    localparam logic [2:0] FR_STAT  = 3'd1;
    localparam logic [2:0] FR_ID    = 3'd2;
    localparam logic [2:0] FR_READ  = 3'd3;
    localparam logic [2:0] FR_ERASE = 3'd4;
    localparam logic [2:0] FR_PROG  = 3'd5;

    localparam logic [7:0] CMD_WEN    = 8'h06;
    localparam logic [7:0] CMD_RDSR   = 8'h05;
    localparam logic [7:0] CMD_READ   = 8'h03;
    localparam logic [7:0] CMD_PROG   = 8'h02;
    localparam logic [7:0] CMD_ERASE  = 8'h20;
    localparam logic [7:0] CMD_JEDEC  = 8'h9F;
    localparam logic [7:0] CMD_REL    = 8'hAB;
    localparam logic [7:0] CMD_RSTEN  = 8'h66;
    localparam logic [7:0] CMD_RST    = 8'h99;
    localparam logic [23:0] ID_ONES   = 24'hFFFFFF;

    logic [4:0]    r_phase, n_phase;
    logic [23:0]   r_op_addr, n_op_addr;
    logic [15:0]   r_op_len, n_op_len;
    logic [15:0]   r_bo, n_bo;
    logic [AW-1:0] r_lp, n_lp;
    logic [15:0]   r_wt, n_wt;
    logic [3:0]    r_retry, n_retry;
    logic [23:0]   r_id_shift, n_id_shift;
    logic          r_ready, n_ready;
    logic [2:0]    r_lerr, n_lerr;
    logic [2:0]    r_fr_kind, n_fr_kind;
    logic [7:0]    r_fr_cmd, n_fr_cmd;
    logic [23:0]   r_fr_addr, n_fr_addr;
    logic [16:0]   r_fr_total, n_fr_total;
    logic [16:0]   r_fr_pos, n_fr_pos;
    logic [7:0]    r_rx, n_rx;
    logic [23:0]   r_idv, n_idv;
    logic          r_for_write, n_for_write;
    logic [15:0]   r_timeout;
    logic [3:0]    r_retry_lim;

    logic          fs_go;
    logic [4:0]    fs_ph;
    logic [2:0]    fs_kind;
    logic [7:0]    fs_cmd;
    logic [23:0]   fs_addr;
    logic [16:0]   fs_total;
    logic          fd_go, fd_ok, dd_go, wb_go;
    logic          term_send, term_done, fin_ok;
    logic [7:0]    fin_byte, tx_byte;
    logic          pre_v;
    logic [7:0]    pre_byte;
    logic          ld_we;
    logic [AW-1:0] rd_addr;
    logic [16:0]   rd_sum;
    logic [16:0]   ch_len;
    logic [7:0]    mem_q;
    logic          idle, delaying;
    t_res          res_pre, res_term;

    function automatic logic [16:0] chunk(input logic [15:0] len, input logic [15:0] bo);
        logic [16:0] rem;
        rem   = {1'b0, len - bo};
        chunk = (rem > 17'(PAGE_BYTES)) ? 17'(PAGE_BYTES) : rem;
    endfunction

    assign idle     = (r_phase == PH_IDLE);
    assign delaying = (r_phase == PH_DLY1) || (r_phase == PH_DLY2) || (r_phase == PH_DLY3);
    assign ch_len   = chunk(r_op_len, r_bo);

    ssq_ram #(.WIDTH(8), .DEPTH(SECTOR_BYTES)) u_buf (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (r_lp),
        .i_wdata (i_item.data_byte),
        .i_raddr (rd_addr),
        .o_rdata (mem_q)
    );

    // prefetch the buffer byte for the next frame position
    assign rd_sum  = {1'b0, n_bo} + n_fr_pos - 17'd3;
    assign rd_addr = rd_sum[AW-1:0];

    always_comb begin
        n_phase = r_phase;   n_op_addr = r_op_addr;   n_op_len = r_op_len;
        n_bo = r_bo;         n_lp = r_lp;             n_wt = r_wt;
        n_retry = r_retry;   n_id_shift = r_id_shift; n_ready = r_ready;
        n_lerr = r_lerr;     n_fr_kind = r_fr_kind;   n_fr_cmd = r_fr_cmd;
        n_fr_addr = r_fr_addr; n_fr_total = r_fr_total; n_fr_pos = r_fr_pos;
        n_rx = r_rx;         n_idv = r_idv;           n_for_write = r_for_write;
        fs_go = 1'b0; fs_ph = PH_IDLE; fs_kind = FR_CMD; fs_cmd = '0;
        fs_addr = '0; fs_total = '0;
        fd_go = 1'b0; fd_ok = 1'b0; dd_go = 1'b0; wb_go = 1'b0;
        term_send = 1'b0; term_done = 1'b0; fin_ok = 1'b0; fin_byte = '0;
        pre_v = 1'b0; pre_byte = '0; ld_we = 1'b0;

        if (i_go) begin
            unique case (i_item.action)
                ACT_INIT: begin
                    if (idle) begin
                        n_for_write = 1'b0;
                        n_retry = '0;
                        fs_go = 1'b1; fs_ph = PH_RST1; fs_cmd = CMD_RSTEN; fs_total = 17'd1;
                    end
                end
                ACT_READ: begin
                    if (idle) begin
                        if (!r_ready) begin
                            n_lerr = ERR_NRDY; term_done = 1'b1;
                        end else begin
                            n_op_addr = i_item.address;
                            n_op_len = i_item.length;
                            fs_go = 1'b1; fs_ph = PH_READ; fs_kind = FR_READ;
                            fs_cmd = CMD_READ; fs_addr = i_item.address;
                            fs_total = 17'd4 + {1'b0, i_item.length};
                        end
                    end
                end
                ACT_LOAD: begin
                    if (idle) begin
                        ld_we = 1'b1;
                        n_lp = (r_lp == AW'(SECTOR_BYTES - 1)) ? '0 : r_lp + 1'b1;
                    end
                end
                ACT_WRITE: begin
                    if (idle) begin
                        n_op_addr = i_item.address;
                        n_op_len = i_item.length;
                        n_lp = '0;
                        if (r_ready) begin
                            wb_go = 1'b1;
                        end else begin
                            n_for_write = 1'b1;
                            n_retry = '0;
                            fs_go = 1'b1; fs_ph = PH_RST1; fs_cmd = CMD_RSTEN;
                            fs_total = 17'd1;
                        end
                    end
                end
                ACT_STATUS: begin
                    if (idle) begin
                        fs_go = 1'b1; fs_ph = PH_STAT; fs_kind = FR_STAT;
                        fs_cmd = CMD_RDSR; fs_total = 17'd2;
                    end
                end
                ACT_RX: begin
                    if (!idle && !delaying) begin
                        if (!i_item.link_ok) begin
                            fd_go = 1'b1;
                        end else begin
                            if (r_fr_kind == FR_STAT && r_fr_pos == 17'd1) begin
                                n_rx = i_item.data_byte;
                            end
                            if (r_fr_kind == FR_ID && r_fr_pos != 17'd0) begin
                                n_id_shift = {r_id_shift[15:0], i_item.data_byte};
                            end
                            if (r_fr_kind == FR_READ && r_fr_pos >= 17'd4) begin
                                pre_v = 1'b1; pre_byte = i_item.data_byte;
                            end
                            if (r_fr_pos + 17'd1 < r_fr_total) begin
                                n_fr_pos = r_fr_pos + 17'd1;
                                term_send = 1'b1;
                            end else begin
                                fd_go = 1'b1; fd_ok = 1'b1;
                            end
                        end
                    end
                end
                ACT_TICK: begin
                    if (!idle) begin
                        if (r_wt != 16'hFFFF) begin
                            n_wt = r_wt + 16'd1;
                        end
                        if ((r_phase == PH_DLY2 && n_wt >= 16'd1) ||
                            ((r_phase == PH_DLY1 || r_phase == PH_DLY3) && n_wt >= 16'd2)) begin
                            dd_go = 1'b1;
                        end
                    end
                end
                ACT_ID: begin
                    if (idle) begin
                        fs_go = 1'b1; fs_ph = PH_IDREAD; fs_kind = FR_ID;
                        fs_cmd = CMD_JEDEC; fs_total = 17'd4;
                    end
                end
                default: ;
            endcase
        end

        if (fd_go) begin
            unique case (r_phase)
                PH_RST1: begin
                    fs_go = 1'b1; fs_ph = PH_RST2; fs_cmd = CMD_RST; fs_total = 17'd1;
                end
                PH_RST2: begin
                    n_phase = PH_DLY1; n_wt = '0;
                end
                PH_REL: begin
                    n_phase = PH_DLY2; n_wt = '0;
                end
                PH_INIT_ID: begin
                    n_idv = fd_ok ? n_id_shift : '0;
                    if (n_idv != '0 && n_idv != ID_ONES) begin
                        n_ready = 1'b1; n_lerr = ERR_NONE;
                        if (r_for_write) begin
                            wb_go = 1'b1;
                        end else begin
                            term_done = 1'b1; fin_ok = 1'b1;
                        end
                    end else begin
                        n_retry = r_retry + 4'd1;
                        n_phase = PH_DLY3; n_wt = '0;
                    end
                end
                PH_READ: begin
                    n_lerr = fd_ok ? ERR_NONE : ERR_NRDY;
                    term_done = 1'b1; fin_ok = fd_ok;
                end
                PH_STAT: begin
                    term_done = 1'b1; fin_ok = fd_ok;
                    if (fd_ok) begin
                        fin_byte = n_rx;
                    end else begin
                        n_lerr = ERR_NRDY; fin_byte = 8'hFF;
                    end
                end
                PH_IDREAD: begin
                    n_idv = fd_ok ? n_id_shift : '0;
                    term_done = 1'b1; fin_ok = fd_ok;
                end
                PH_W_WEN, PH_P_WEN: begin
                    if (!fd_ok) begin
                        n_lerr = ERR_WEN; term_done = 1'b1;
                    end else begin
                        fs_go = 1'b1; fs_ph = r_phase + 5'd1; fs_kind = FR_STAT;
                        fs_cmd = CMD_RDSR; fs_total = 17'd2;
                    end
                end
                PH_W_WEL: begin
                    if (!fd_ok || !n_rx[1]) begin
                        n_lerr = ERR_WEN; term_done = 1'b1;
                    end else begin
                        fs_go = 1'b1; fs_ph = PH_W_ERASE; fs_kind = FR_ERASE;
                        fs_cmd = CMD_ERASE; fs_addr = r_op_addr; fs_total = 17'd4;
                    end
                end
                PH_P_WEL: begin
                    if (!fd_ok || !n_rx[1]) begin
                        n_lerr = ERR_WEN; term_done = 1'b1;
                    end else begin
                        fs_go = 1'b1; fs_ph = PH_P_PROG; fs_kind = FR_PROG;
                        fs_cmd = CMD_PROG; fs_addr = r_op_addr + {8'd0, r_bo};
                        fs_total = 17'd4 + ch_len;
                    end
                end
                PH_W_ERASE, PH_P_PROG: begin
                    if (!fd_ok) begin
                        n_lerr = (r_phase == PH_W_ERASE) ? ERR_ERASE : ERR_PROG;
                        term_done = 1'b1;
                    end else begin
                        n_wt = '0;
                        fs_go = 1'b1; fs_ph = r_phase + 5'd1; fs_kind = FR_STAT;
                        fs_cmd = CMD_RDSR; fs_total = 17'd2;
                    end
                end
                PH_W_POLL, PH_P_POLL: begin
                    if (!fd_ok) begin
                        n_lerr = ERR_WAIT; term_done = 1'b1;
                    end else if (n_rx[0]) begin
                        if (r_wt < r_timeout) begin
                            fs_go = 1'b1; fs_ph = r_phase; fs_kind = FR_STAT;
                            fs_cmd = CMD_RDSR; fs_total = 17'd2;
                        end else begin
                            n_lerr = ERR_WAIT; term_done = 1'b1;
                        end
                    end else begin
                        if (r_phase == PH_P_POLL) begin
                            n_bo = r_bo + ch_len[15:0];
                        end
                        if (n_bo < r_op_len) begin
                            fs_go = 1'b1; fs_ph = PH_P_WEN; fs_cmd = CMD_WEN;
                            fs_total = 17'd1;
                        end else begin
                            n_lerr = ERR_NONE; term_done = 1'b1; fin_ok = 1'b1;
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end

        if (dd_go) begin
            if (r_phase == PH_DLY1) begin
                fs_go = 1'b1; fs_ph = PH_REL; fs_cmd = CMD_REL; fs_total = 17'd1;
            end else if (r_retry < r_retry_lim) begin
                fs_go = 1'b1; fs_ph = PH_INIT_ID; fs_kind = FR_ID;
                fs_cmd = CMD_JEDEC; fs_total = 17'd4;
            end else begin
                n_ready = 1'b0; n_lerr = ERR_NRDY; term_done = 1'b1;
            end
        end

        if (wb_go) begin
            if (n_op_len == '0 || {1'b0, n_op_len} > 17'(SECTOR_BYTES)) begin
                n_lerr = ERR_PARAM; term_done = 1'b1;
            end else begin
                n_op_addr = n_op_addr & ~24'(SECTOR_BYTES - 1);
                n_bo = '0;
                fs_go = 1'b1; fs_ph = PH_W_WEN; fs_cmd = CMD_WEN; fs_total = 17'd1;
            end
        end

        if (term_done) begin
            n_phase = PH_IDLE;
        end

        if (fs_go) begin
            n_phase = fs_ph; n_fr_kind = fs_kind; n_fr_cmd = fs_cmd;
            n_fr_addr = fs_addr; n_fr_total = fs_total; n_fr_pos = '0;
            if (fs_kind == FR_ID) begin
                n_id_shift = '0;
            end
            term_send = 1'b1;
        end

        if (n_fr_pos == '0) begin
            tx_byte = n_fr_cmd;
        end else if ((n_fr_kind == FR_READ || n_fr_kind == FR_ERASE || n_fr_kind == FR_PROG)
                     && n_fr_pos <= 17'd3) begin
            tx_byte = (n_fr_pos == 17'd1) ? n_fr_addr[23:16] :
                      (n_fr_pos == 17'd2) ? n_fr_addr[15:8] : n_fr_addr[7:0];
        end else if (n_fr_kind == FR_PROG) begin
            tx_byte = mem_q;
        end else begin
            tx_byte = 8'hFF;
        end
    end

    always_comb begin
        res_pre.kind         = K_RDATA;
        res_pre.byte_value   = pre_byte;
        res_pre.frame_end    = 1'b0;
        res_pre.success      = 1'b0;
        res_pre.error_code   = r_lerr;
        res_pre.jedec_id     = r_idv;
        res_pre.device_ready = r_ready;
        res_pre.last         = !(term_send || term_done);

        res_term.kind         = term_send ? K_SPI : K_DONE;
        res_term.byte_value   = term_send ? tx_byte : fin_byte;
        res_term.frame_end    = term_send && (n_fr_pos + 17'd1 >= n_fr_total);
        res_term.success      = term_done && !term_send && fin_ok;
        res_term.error_code   = n_lerr;
        res_term.jedec_id     = n_idv;
        res_term.device_ready = n_ready;
        res_term.last         = 1'b1;
    end

    assign o_push_n = 2'(pre_v) + 2'(term_send || term_done);
    assign o_res0   = pre_v ? res_pre : res_term;
    assign o_res1   = res_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_retry_lim <= RETRY_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data;
            end else if (i_cfg_index == CFG_RETRY) begin
                r_retry_lim <= i_cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_op_addr <= '0; r_op_len <= '0; r_bo <= '0;
            r_lp <= '0; r_wt <= '0; r_retry <= '0; r_id_shift <= '0;
            r_ready <= 1'b0; r_lerr <= ERR_NONE; r_fr_kind <= FR_CMD;
            r_fr_cmd <= '0; r_fr_addr <= '0; r_fr_total <= '0; r_fr_pos <= '0;
            r_rx <= '0; r_idv <= '0; r_for_write <= 1'b0;
        end else begin
            r_phase <= n_phase; r_op_addr <= n_op_addr; r_op_len <= n_op_len;
            r_bo <= n_bo; r_lp <= n_lp; r_wt <= n_wt; r_retry <= n_retry;
            r_id_shift <= n_id_shift; r_ready <= n_ready; r_lerr <= n_lerr;
            r_fr_kind <= n_fr_kind; r_fr_cmd <= n_fr_cmd; r_fr_addr <= n_fr_addr;
            r_fr_total <= n_fr_total; r_fr_pos <= n_fr_pos; r_rx <= n_rx;
            r_idv <= n_idv; r_for_write <= n_for_write;
        end
    end
endmodule

[src/spi_nor_flash_sector_sequencer_top.sv]
// Top level of the SPI NOR flash sector sequencer.
// Input channel (i_valid / o_stall) carries host requests, ticks and the byte
// clocked back from the flash for every byte sent. Output channel (o_valid /
// i_stall) carries SPI bytes to send (o_frame_end closes chip select), read
// data to the host and one done beat per operation; o_last marks the final
// result of each input beat.
// An input beat sits in a 4-entry queue, is executed by the sequencer as it leaves
// the queue, and its results are registered in the result queue before they reach the
// output. One beat per cycle is sustained while each beat yields at most one result
// and the output is not stalled; the 4-entry result queue sets the figure, since the
// sequencer only takes a beat when two result slots are free.
// The sector buffer is a 4096x8 RAM with a registered read; program bytes are
// prefetched one position ahead.
// Reset empties both queues, returns the sequencer to idle and restores the
// register defaults; buffer contents are kept. A stalled output holds its beat;
// when the input queue fills up, o_stall rises.
module spi_nor_flash_sector_sequencer_top #(
    parameter int PAGE_BYTES   = ssq_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = ssq_pkg::SECTOR_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [23:0] i_address,
    input  logic [15:0] i_length,
    input  logic [7:0]  i_data_byte,
    input  logic        i_link_ok,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_byte_value,
    output logic        o_frame_end,
    output logic        o_success,
    output logic [2:0]  o_error_code,
    output logic [23:0] o_jedec_id,
    output logic        o_device_ready,
    output logic        o_last
);
    import ssq_pkg::*;

    t_item      in_item, q_item;
    t_res       res0, res1, out_res;
    logic       q_avail, room2, go;
    logic [1:0] push_n;

    assign in_item.action    = i_action;
    assign in_item.address   = i_address;
    assign in_item.length    = i_length;
    assign in_item.data_byte = i_data_byte;
    assign in_item.link_ok   = i_link_ok;

    assign go = q_avail && room2;

    ssq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .i_pop   (go),
        .o_avail (q_avail),
        .o_item  (q_item)
    );

    ssq_back #(.PAGE_BYTES(PAGE_BYTES), .SECTOR_BYTES(SECTOR_BYTES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_go        (go),
        .i_item      (q_item),
        .o_push_n    (push_n),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    ssq_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res0   (res0),
        .i_res1   (res1),
        .o_room2  (room2),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_res    (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_byte_value   = out_res.byte_value;
    assign o_frame_end    = out_res.frame_end;
    assign o_success      = out_res.success;
    assign o_error_code   = out_res.error_code;
    assign o_jedec_id     = out_res.jedec_id;
    assign o_device_ready = out_res.device_ready;
    assign o_last         = out_res.last;
endmodule

[src/ssq_checker.sv]
// Port-level checks of the sector sequencer, bound to the top level.
`include "spi_nor_flash_sector_sequencer_top_macros.svh"

module ssq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_byte_value,
    input logic        o_frame_end,
    input logic        o_success,
    input logic        o_device_ready,
    input logic        o_last
);
    import ssq_pkg::*;

    `SSQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_kind) && $stable(o_byte_value) && $stable(o_last))
    `SSQ_ASSERT_NOW(a_fe_spi, i_clk, i_rst_n, o_valid && o_frame_end, o_kind == K_SPI)
    `SSQ_ASSERT_NOW(a_ok_done, i_clk, i_rst_n, o_valid && o_success, o_kind == K_DONE && o_last)
    `SSQ_ASSERT_NOW(a_rd_ready, i_clk, i_rst_n, o_valid && o_kind == K_RDATA, o_device_ready)
endmodule

bind spi_nor_flash_sector_sequencer_top ssq_checker u_ssq_checker (.*);

[tb/sv/ssq_flash_checker.sv]
// Sector sequencer checker: watches both channels, predicts result beats and compares them.
`timescale 1ns / 100ps
module ssq_flash_checker
    import ssq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_action,
    input  logic [23:0] i_address,
    input  logic [15:0] i_length,
    input  logic [7:0]  i_data_byte,
    input  logic        i_link_ok,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_byte_value,
    input  logic        i_frame_end,
    input  logic        i_success,
    input  logic [2:0]  i_error_code,
    input  logic [23:0] i_jedec_id,
    input  logic        i_device_ready,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_idle,
    output logic        o_ready,
    output int          o_beats_in,
    output int          o_beats_out
);

    localparam int unsigned PAGE   = 256;
    localparam int unsigned SECTOR = 4096;

    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_PP    = 8'h02;
    localparam logic [7:0] CMD_SE    = 8'h20;
    localparam logic [7:0] CMD_RDID  = 8'h9F;
    localparam logic [7:0] CMD_RES   = 8'hAB;
    localparam logic [7:0] CMD_RSTEN = 8'h66;
    localparam logic [7:0] CMD_RST   = 8'h99;
    localparam logic [7:0] SR_BUSY   = 8'h01;
    localparam logic [7:0] SR_WEL    = 8'h02;
    localparam logic [23:0] ID_ONES  = 24'hFFFFFF;

    typedef enum int {
        ST_IDLE, ST_RST1, ST_RST2, ST_DLY1, ST_REL, ST_DLY2, ST_INIT_ID, ST_DLY3,
        ST_READ, ST_STAT, ST_IDREAD, ST_W_WEN, ST_W_WEL, ST_W_ERASE, ST_W_POLL,
        ST_P_WEN, ST_P_WEL, ST_P_PROG, ST_P_POLL
    } seq_state_e;

    typedef enum int {FR_CMD, FR_STAT, FR_ID, FR_READ, FR_ERASE, FR_PROG} frame_e;

    logic [7:0]  sector_mem [0:SECTOR-1];
    seq_state_e  st;
    int unsigned op_addr, op_len, offs, load_ptr, wtimer, retries;
    logic [23:0] id_acc, id_rep;
    logic        rdy;
    logic [2:0]  err;
    logic [15:0] tmo;
    logic [3:0]  retry_lim;
    frame_e      fk;
    logic [7:0]  fcmd;
    logic [23:0] faddr;
    int unsigned ftotal, fpos;
    logic [7:0]  sr_byte;
    logic        init_for_write;

    t_res step_res[$];
    t_res flash_beats_due[$];
    int   fails, n_in, n_out;

    assign o_fail_count = fails;
    assign o_pending    = flash_beats_due.size();
    assign o_idle       = (st == ST_IDLE);
    assign o_ready      = rdy;
    assign o_beats_in   = n_in;
    assign o_beats_out  = n_out;

    task automatic report(string msg);
        $display("%0t mismatch: %s", $time, msg);
        fails++;
    endtask

    task automatic emit(logic [1:0] k, logic [7:0] b, logic fe, logic ok);
        t_res r;
        r.kind = k;
        r.byte_value = b;
        r.frame_end = fe;
        r.success = ok;
        r.error_code = err;
        r.jedec_id = id_rep;
        r.device_ready = rdy;
        r.last = 1'b0;
        step_res.push_back(r);
    endtask

    function automatic logic [7:0] cur_byte();
        int unsigned idx;
        if (fpos == 0) return fcmd;
        if ((fk == FR_READ || fk == FR_ERASE || fk == FR_PROG) && fpos <= 3)
            return 8'(faddr >> (8 * (3 - fpos)));
        if (fk == FR_PROG) begin
            idx = offs + fpos - 4;
            return (idx < SECTOR) ? sector_mem[idx] : 8'h00;
        end
        return 8'hFF;
    endfunction

    task automatic send_cur();
        emit(K_SPI, cur_byte(), (fpos + 1 >= ftotal), 1'b0);
    endtask

    task automatic start_frame(seq_state_e p, frame_e k, logic [7:0] c, int unsigned a,
                               int unsigned tot);
        st = p;
        fk = k;
        fcmd = c;
        faddr = a[23:0];
        ftotal = tot;
        fpos = 0;
        if (k == FR_ID) id_acc = '0;
        send_cur();
    endtask

    task automatic finish_op(logic ok, logic [7:0] b);
        st = ST_IDLE;
        emit(K_DONE, b, 1'b0, ok);
    endtask

    task automatic fail_op(logic [2:0] code);
        err = code;
        finish_op(1'b0, 8'h00);
    endtask

    function automatic int unsigned chunk();
        int unsigned r;
        r = op_len - offs;
        return (r > PAGE) ? PAGE : r;
    endfunction

    task automatic write_begin();
        if (op_len == 0 || op_len > SECTOR) begin
            fail_op(ERR_PARAM);
            return;
        end
        op_addr = op_addr - (op_addr % SECTOR);
        offs = 0;
        start_frame(ST_W_WEN, FR_CMD, CMD_WREN, 0, 1);
    endtask

    task automatic init_start();
        retries = 0;
        start_frame(ST_RST1, FR_CMD, CMD_RSTEN, 0, 1);
    endtask

    task automatic delay_done();
        if (st == ST_DLY1) begin
            start_frame(ST_REL, FR_CMD, CMD_RES, 0, 1);
        end else if (retries < retry_lim) begin
            start_frame(ST_INIT_ID, FR_ID, CMD_RDID, 0, 4);
        end else begin
            rdy = 1'b0;
            fail_op(ERR_NRDY);
        end
    endtask

    task automatic frame_done(logic ok);
        case (st)
            ST_RST1: start_frame(ST_RST2, FR_CMD, CMD_RST, 0, 1);
            ST_RST2: begin
                st = ST_DLY1;
                wtimer = 0;
            end
            ST_REL: begin
                st = ST_DLY2;
                wtimer = 0;
            end
            ST_INIT_ID: begin
                id_rep = ok ? id_acc : 24'h0;
                if (id_rep != 0 && id_rep != ID_ONES) begin
                    rdy = 1'b1;
                    err = ERR_NONE;
                    if (init_for_write) write_begin();
                    else finish_op(1'b1, 8'h00);
                end else begin
                    retries++;
                    st = ST_DLY3;
                    wtimer = 0;
                end
            end
            ST_READ: begin
                if (ok) begin
                    err = ERR_NONE;
                    finish_op(1'b1, 8'h00);
                end else begin
                    fail_op(ERR_NRDY);
                end
            end
            ST_STAT: begin
                if (ok) begin
                    finish_op(1'b1, sr_byte);
                end else begin
                    err = ERR_NRDY;
                    finish_op(1'b0, 8'hFF);
                end
            end
            ST_IDREAD: begin
                id_rep = ok ? id_acc : 24'h0;
                finish_op(ok, 8'h00);
            end
            ST_W_WEN, ST_P_WEN: begin
                if (!ok) fail_op(ERR_WEN);
                else start_frame((st == ST_W_WEN) ? ST_W_WEL : ST_P_WEL, FR_STAT, CMD_RDSR, 0, 2);
            end
            ST_W_WEL: begin
                if (!ok || (sr_byte & SR_WEL) == 0) fail_op(ERR_WEN);
                else start_frame(ST_W_ERASE, FR_ERASE, CMD_SE, op_addr, 4);
            end
            ST_P_WEL: begin
                if (!ok || (sr_byte & SR_WEL) == 0) fail_op(ERR_WEN);
                else start_frame(ST_P_PROG, FR_PROG, CMD_PP, op_addr + offs, 4 + chunk());
            end
            ST_W_ERASE, ST_P_PROG: begin
                if (!ok) begin
                    fail_op((st == ST_W_ERASE) ? ERR_ERASE : ERR_PROG);
                end else begin
                    wtimer = 0;
                    start_frame((st == ST_W_ERASE) ? ST_W_POLL : ST_P_POLL, FR_STAT, CMD_RDSR,
                                0, 2);
                end
            end
            ST_W_POLL, ST_P_POLL: begin
                if (!ok) begin
                    fail_op(ERR_WAIT);
                end else if ((sr_byte & SR_BUSY) != 0) begin
                    if (wtimer < tmo) start_frame(st, FR_STAT, CMD_RDSR, 0, 2);
                    else fail_op(ERR_WAIT);
                end else begin
                    if (st == ST_P_POLL) offs += chunk();
                    if (offs < op_len) begin
                        start_frame(ST_P_WEN, FR_CMD, CMD_WREN, 0, 1);
                    end else begin
                        err = ERR_NONE;
                        finish_op(1'b1, 8'h00);
                    end
                end
            end
            default: st = ST_IDLE;
        endcase
    endtask

    task automatic on_rx(logic [7:0] b, logic ok);
        if (!ok) begin
            frame_done(1'b0);
            return;
        end
        if (fk == FR_STAT && fpos == 1) sr_byte = b;
        if (fk == FR_ID && fpos >= 1) id_acc = {id_acc[15:0], b};
        if (fk == FR_READ && fpos >= 4) emit(K_RDATA, b, 1'b0, 1'b0);
        if (fpos + 1 < ftotal) begin
            fpos++;
            send_cur();
        end else begin
            frame_done(1'b1);
        end
    endtask

    task automatic step(t_item it);
        logic is_idle, delaying;
        is_idle = (st == ST_IDLE);
        delaying = (st == ST_DLY1 || st == ST_DLY2 || st == ST_DLY3);
        step_res.delete();
        case (it.action)
            ACT_INIT: begin
                if (is_idle) begin
                    init_for_write = 1'b0;
                    init_start();
                end
            end
            ACT_READ: begin
                if (is_idle) begin
                    if (!rdy) begin
                        fail_op(ERR_NRDY);
                    end else begin
                        op_addr = it.address;
                        op_len = it.length;
                        start_frame(ST_READ, FR_READ, CMD_READ, it.address, 4 + it.length);
                    end
                end
            end
            ACT_LOAD: begin
                if (is_idle) begin
                    sector_mem[load_ptr] = it.data_byte;
                    load_ptr = (load_ptr + 1 >= SECTOR) ? 0 : load_ptr + 1;
                end
            end
            ACT_WRITE: begin
                if (is_idle) begin
                    op_addr = it.address;
                    op_len = it.length;
                    load_ptr = 0;
                    if (rdy) begin
                        write_begin();
                    end else begin
                        init_for_write = 1'b1;
                        init_start();
                    end
                end
            end
            ACT_STATUS: if (is_idle) start_frame(ST_STAT, FR_STAT, CMD_RDSR, 0, 2);
            ACT_RX: if (!is_idle && !delaying) on_rx(it.data_byte, it.link_ok);
            ACT_TICK: begin
                if (!is_idle) begin
                    if (wtimer < 65535) wtimer++;
                    if ((st == ST_DLY2 && wtimer >= 1) ||
                        ((st == ST_DLY1 || st == ST_DLY3) && wtimer >= 2))
                        delay_done();
                end
            end
            ACT_ID: if (is_idle) start_frame(ST_IDREAD, FR_ID, CMD_RDID, 0, 4);
        endcase
        if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[i]) flash_beats_due.push_back(step_res[i]);
    endtask

    task automatic cmp(string name, int got, int want);
        if (got != want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_item it;
        t_res e;
        if (!i_rst_n) begin
            st = ST_IDLE;
            op_addr = 0; op_len = 0; offs = 0; load_ptr = 0; wtimer = 0; retries = 0;
            id_acc = '0; id_rep = '0; rdy = 1'b0; err = ERR_NONE;
            tmo = TIMEOUT_RST; retry_lim = RETRY_RST;
            fk = FR_CMD; fcmd = '0; faddr = '0; ftotal = 0; fpos = 0;
            sr_byte = '0; init_for_write = 1'b0;
            flash_beats_due.delete();
            fails = 0; n_in = 0; n_out = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                n_out++;
                if (flash_beats_due.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    e = flash_beats_due.pop_front();
                    cmp("kind", i_kind, e.kind);
                    cmp("byte_value", i_byte_value, e.byte_value);
                    cmp("frame_end", i_frame_end, e.frame_end);
                    cmp("success", i_success, e.success);
                    cmp("error_code", i_error_code, e.error_code);
                    cmp("jedec_id", i_jedec_id, e.jedec_id);
                    cmp("device_ready", i_device_ready, e.device_ready);
                    cmp("last", i_last, e.last);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TIMEOUT) tmo = i_cfg_data;
                else if (i_cfg_index == CFG_RETRY) retry_lim = i_cfg_data[3:0];
            end
            if (i_in_valid && !i_in_stall) begin
                n_in++;
                it.action = i_action;
                it.address = i_address;
                it.length = i_length;
                it.data_byte = i_data_byte;
                it.link_ok = i_link_ok;
                step(it);
            end
        end
    end

endmodule

[tb/sv/spi_nor_flash_sector_sequencer_top_tb.sv]
// Testbench top for the sector sequencer: flash-side stimulus, stall profiles and verdict.
`timescale 1ns / 100ps
module spi_nor_flash_sector_sequencer_top_tb;
    import ssq_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic [7:0] SR_BUSY = 8'h01;
    localparam logic [7:0] SR_WEL  = 8'h02;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid, o_stall;
    logic [2:0]  i_action;
    logic [23:0] i_address;
    logic [15:0] i_length;
    logic [7:0]  i_data_byte;
    logic        i_link_ok;
    logic        o_valid, i_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_byte_value;
    logic        o_frame_end, o_success;
    logic [2:0]  o_error_code;
    logic [23:0] o_jedec_id;
    logic        o_device_ready, o_last;

    int   fail_count, pending, beats_in, beats_out;
    logic model_idle, model_ready;

    int tx_gap_pct, rx_stall_pct, link_fail_pct, busy_pct;
    int sent, hold_asked, hold_seen, hold_left;

    spi_nor_flash_sector_sequencer_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_address(i_address), .i_length(i_length),
        .i_data_byte(i_data_byte), .i_link_ok(i_link_ok),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_kind(o_kind), .o_byte_value(o_byte_value), .o_frame_end(o_frame_end),
        .o_success(o_success), .o_error_code(o_error_code), .o_jedec_id(o_jedec_id),
        .o_device_ready(o_device_ready), .o_last(o_last)
    );

    ssq_flash_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_action(i_action), .i_address(i_address), .i_length(i_length),
        .i_data_byte(i_data_byte), .i_link_ok(i_link_ok),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_kind(o_kind), .i_byte_value(o_byte_value), .i_frame_end(o_frame_end),
        .i_success(o_success), .i_error_code(o_error_code), .i_jedec_id(o_jedec_id),
        .i_device_ready(o_device_ready), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending), .o_idle(model_idle),
        .o_ready(model_ready), .o_beats_in(beats_in), .o_beats_out(beats_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        i_stall = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_asked != hold_seen) begin
                hold_seen = hold_asked;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else begin
                i_stall = ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    task automatic send(logic [2:0] a, logic [23:0] ad, logic [15:0] ln, logic [7:0] b,
                        logic lk);
        if ($urandom_range(99) < tx_gap_pct) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_action = a;
        i_address = ad;
        i_length = ln;
        i_data_byte = b;
        i_link_ok = lk;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic rx_link(logic [7:0] b, logic lk);
        send(ACT_RX, 24'($urandom), 16'($urandom), b, lk);
    endtask

    task automatic rx(logic [7:0] b);
        rx_link(b, $urandom_range(99) >= link_fail_pct);
    endtask

    task automatic tick();
        send(ACT_TICK, 24'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic id_attempts();
        logic [23:0] id;
        for (int n = 0; n < 4; n++) begin
            rx(8'($urandom));
            if ($urandom_range(9) < 7) id = 24'($urandom_range(1, 24'hFFFFFE));
            else id = $urandom_range(1) ? 24'h0 : 24'hFFFFFF;
            rx(id[23:16]);
            rx(id[15:8]);
            rx(id[7:0]);
            if (model_idle || model_ready) break;
            tick();
            tick();
        end
    endtask

    task automatic init_body();
        rx(8'($urandom));
        rx(8'($urandom));
        tick();
        tick();
        rx(8'($urandom));
        tick();
        id_attempts();
    endtask

    task automatic wel_seq();
        rx(8'($urandom));
        rx(8'($urandom));
        rx(($urandom_range(19) > 0) ? (8'($urandom) | SR_WEL) : (8'($urandom) & ~SR_WEL));
    endtask

    task automatic poll_seq();
        logic busy;
        for (int n = 0; n < 8; n++) begin
            rx(8'($urandom));
            busy = ($urandom_range(99) < busy_pct) && (n < 7);
            rx(busy ? (8'($urandom) | SR_BUSY) : (8'($urandom) & ~SR_BUSY));
            if (!busy) break;
            repeat ($urandom_range(0, 2)) tick();
        end
    endtask

    task automatic sector_write(logic [23:0] ad, logic [15:0] ln, int nload);
        int part;
        repeat (nload) send(ACT_LOAD, 24'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
        send(ACT_WRITE, ad, ln, 8'($urandom), 1'($urandom));
        if (!model_ready) init_body();
        if (ln == 0 || ln > 4096) return;
        wel_seq();
        repeat (4) rx(8'($urandom));
        poll_seq();
        for (int o = 0; o < ln; o += 256) begin
            part = (ln - o > 256) ? 256 : ln - o;
            wel_seq();
            repeat (4 + part) rx(8'($urandom));
            poll_seq();
        end
    endtask

    task automatic flash_read(logic [23:0] ad, logic [15:0] ln);
        send(ACT_READ, ad, ln, 8'($urandom), 1'($urandom));
        if (!model_idle) repeat (4 + ln) rx(8'($urandom));
    endtask

    task automatic status_read();
        send(ACT_STATUS, 24'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
        rx(8'($urandom));
        rx(8'($urandom));
    endtask

    task automatic id_read();
        send(ACT_ID, 24'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
        repeat (4) rx(8'($urandom));
    endtask

    task automatic random_op();
        logic [15:0] ln;
        case ($urandom_range(0, 9))
            0: begin
                send(ACT_INIT, 24'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
                init_body();
            end
            1, 2: flash_read(24'($urandom), 16'($urandom_range(0, 12)));
            3: status_read();
            4: id_read();
            5, 6, 7: begin
                case ($urandom_range(0, 9))
                    0: ln = 16'd0;
                    1: ln = 16'($urandom_range(4097, 65535));
                    2: ln = 16'($urandom_range(25, 64));
                    default: ln = 16'($urandom_range(1, 24));
                endcase
                sector_write(24'($urandom), ln, $urandom_range(0, 6));
            end
            default: begin
                repeat ($urandom_range(1, 3))
                    send(3'($urandom), 24'($urandom), 16'($urandom), 8'($urandom),
                         1'($urandom));
            end
        endcase
    endtask

    // bring the sequencer back to idle and let every result drain
    task automatic settle();
        while (!model_idle) begin
            if ($urandom_range(1)) rx_link(8'($urandom), 1'b0);
            else tick();
        end
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_round(int n);
        int goal;
        goal = sent + n;
        while (sent < goal) random_op();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_TIMEOUT;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_action = ACT_INIT;
        i_address = '0;
        i_length = '0;
        i_data_byte = '0;
        i_link_ok = 1'b0;
        tx_gap_pct = 8;
        rx_stall_pct = 50;
        link_fail_pct = 3;
        busy_pct = 0;
        sent = 0;
        hold_asked = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        cfg_write(CFG_TIMEOUT, 16'd1);
        cfg_write(CFG_RETRY, 16'd15);
        cfg_write(CFG_UNUSED, 16'hFFFF);

        // fill the start of the sector buffer, enough for every write length used
        send(ACT_LOAD, 24'hFFFFFF, 16'hFFFF, 8'h00, 1'b1);
        send(ACT_LOAD, 24'h0, 16'h0, 8'hFF, 1'b0);
        repeat (255) send(ACT_LOAD, 24'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));

        link_fail_pct = 0;
        flash_read(24'hFFFFFF, 16'hFFFF);
        status_read();
        id_read();
        sector_write(24'hFFFFFF, 16'd0, 0);
        flash_read(24'h000000, 16'd2);
        send(ACT_READ, 24'h123456, 16'hFFFF, 8'h00, 1'b1);
        repeat (5) rx(8'($urandom));
        rx_link(8'h00, 1'b0);
        sector_write(24'($urandom), 16'd257, 0);
        sector_write(24'h000000, 16'd4097, 0);
        send(ACT_WRITE, 24'h001000, 16'd4, 8'h00, 1'b1);
        rx_link(8'h00, 1'b0);
        send(ACT_WRITE, 24'h002000, 16'd4, 8'h00, 1'b1);
        rx(8'h00);
        rx(8'h00);
        rx(8'h00);
        send(ACT_WRITE, 24'h003000, 16'd4, 8'h00, 1'b1);
        wel_seq();
        rx(8'h20);
        rx_link(8'h00, 1'b0);
        send(ACT_WRITE, 24'h004000, 16'd4, 8'h00, 1'b1);
        wel_seq();
        repeat (4) rx(8'h00);
        rx(8'h00);
        rx(8'h00);
        wel_seq();
        rx_link(8'h00, 1'b0);
        send(ACT_WRITE, 24'h005000, 16'd4, 8'h00, 1'b1);
        wel_seq();
        repeat (4) rx(8'h00);
        rx(8'h00);
        rx_link(8'h00, 1'b0);
        send(ACT_WRITE, 24'h006000, 16'd4, 8'h00, 1'b1);
        wel_seq();
        repeat (4) rx(8'h00);
        rx(8'h00);
        rx(SR_BUSY);
        tick();
        rx(8'h00);
        rx(SR_BUSY);
        link_fail_pct = 3;
        busy_pct = 35;
        settle();

        cfg_write(CFG_TIMEOUT, 16'hFFFF);
        cfg_write(CFG_RETRY, 16'd1);
        tx_gap_pct = 50;
        rx_stall_pct = 8;
        random_round(30);
        settle();

        cfg_write(CFG_RETRY, 16'd0);
        send(ACT_INIT, 24'h0, 16'h0, 8'h00, 1'b1);
        init_body();
        settle();
        cfg_write(CFG_TIMEOUT, 16'd3);
        cfg_write(CFG_RETRY, 16'd5);
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        hold_asked++;
        repeat (8) status_read();
        random_round(40);
        settle();

        $display("Covered %0d input beats and %0d result beats: init, reads, status, id,",
                 beats_in, beats_out);
        $display("single and multi-page sector writes, error paths and three stall profiles.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
